FILE: hw/rtl/lrd_pkg.sv
package lrd_pkg;

  localparam int unsigned CrcWidth = 32;
  localparam int unsigned LenWidth = 32;

  localparam logic [CrcWidth-1:0] CRC_ONES = 32'hFFFF_FFFF;
  localparam logic [CrcWidth-1:0] CRC_POLY = 32'hEDB8_8320;

  // Parse phases.
  localparam logic [2:0] PH_TYPE = 3'd0;
  localparam logic [2:0] PH_KLEN = 3'd1;
  localparam logic [2:0] PH_VLEN = 3'd2;
  localparam logic [2:0] PH_KEY  = 3'd3;
  localparam logic [2:0] PH_VAL  = 3'd4;
  localparam logic [2:0] PH_CSUM = 3'd5;

  // Result kinds.
  localparam logic [1:0] KIND_KEY = 2'd0;
  localparam logic [1:0] KIND_VAL = 2'd1;
  localparam logic [1:0] KIND_REC = 2'd2;
  localparam logic [1:0] KIND_LOG = 2'd3;

  // Status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_MISMATCH  = 3'd1;
  localparam logic [2:0] ST_TRUNC_KLEN = 3'd2;
  localparam logic [2:0] ST_TRUNC_VLEN = 3'd3;
  localparam logic [2:0] ST_TRUNC_KEY  = 3'd4;
  localparam logic [2:0] ST_TRUNC_VAL  = 3'd5;
  localparam logic [2:0] ST_TRUNC_CSUM = 3'd6;

  // Configuration register addresses (word index).
  localparam logic REG_END_MARKER = 1'b0;

  typedef struct packed {
    logic [1:0]          kind;
    logic [7:0]          data;
    logic [7:0]          rtype;
    logic [LenWidth-1:0] ksz;
    logic [LenWidth-1:0] vsz;
    logic [2:0]          status;
  } lrd_result_t;

endpackage

FILE: hw/rtl/log_record_deframer_crc32_top.sv
// Log record deframer with CRC-32 check.
// The input channel (in_valid/in_ready) carries one beat per log byte in
// byte_value, or a stream end when stream_done is high. The output channel
// (out_valid/out_ready) carries at most one result beat per input beat: a key
// byte, a value byte, a record end with its checksum status, or a log end.
// A beat is registered on entry, parsed once the output register can take a
// result, and its result lands in the output register.
// The parser keeps the CRC, the length counters and the phase in flip-flops,
// and the byte-wide CRC step plus one counter decrement are combinational, so
// one byte per cycle is sustained while the receiver does not stall.
// When the receiver stalls, the output register holds its beat and the input
// register keeps one more beat; input then stops until the output drains.
// Reset clears the parser to expect a type byte, the CRC to all ones and the
// end-marker register to zero. After any log end or checksum mismatch every
// further beat is accepted and dropped until the next reset.
// The end-marker type sits at byte address 0 of the APB port.
module log_record_deframer_crc32_top import lrd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_value,
  input  logic        stream_done,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic [7:0]  data_byte,
  output logic [7:0]  record_type,
  output logic [31:0] key_size,
  output logic [31:0] value_size,
  output logic [2:0]  status
);

  logic        end_marker;
  logic [7:0]  end_marker_type;
  logic        in_q_valid;
  logic [7:0]  byte_q;
  logic        done_q;
  logic        advance;
  logic        step;
  logic        res_valid;
  lrd_result_t res;
  lrd_result_t out_q;

  assign end_marker = (paddr[2] == REG_END_MARKER);
  assign pready     = 1'b1;
  assign prdata     = end_marker ? {24'd0, end_marker_type} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      end_marker_type <= 8'd0;
    end else if (psel && penable && pwrite && end_marker) begin
      end_marker_type <= pwdata[7:0];
    end
  end

  // The whole pipe moves whenever the output register is free or being read.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !in_q_valid || advance;
  assign step     = in_q_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_q <= byte_value;
      done_q <= stream_done;
    end
  end

  lrd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .byte_in    (byte_q),
    .done_in    (done_q),
    .end_marker (end_marker_type),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign result_kind = out_q.kind;
  assign data_byte   = out_q.data;
  assign record_type = out_q.rtype;
  assign key_size    = out_q.ksz;
  assign value_size  = out_q.vsz;
  assign status      = out_q.status;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while the output register is empty");

  a_byte_status_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (result_kind == KIND_KEY || result_kind == KIND_VAL))
      |-> (status == ST_OK))
    else $error("key or value byte carries a non-zero status");

  a_no_data_on_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (result_kind == KIND_REC || result_kind == KIND_LOG))
      |-> (data_byte == 8'd0))
    else $error("record or log end carries a data byte");

  a_silent_after_log_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && result_kind == KIND_LOG) |=> !out_valid)
    else $error("result produced after a log end");

endmodule

FILE: hw/rtl/lrd_parser.sv
module lrd_parser import lrd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  byte_in,
  input  logic        done_in,
  input  logic [7:0]  end_marker,
  output logic        res_valid,
  output lrd_result_t res
);

  logic [2:0]          phase, phase_next;
  logic [1:0]          field_byte_count, field_byte_count_next;
  logic [LenWidth-1:0] length_shift, length_shift_next;
  logic [LenWidth-1:0] key_len_reg, key_len_reg_next;
  logic [LenWidth-1:0] value_len_reg, value_len_reg_next;
  logic [LenWidth-1:0] bytes_left, bytes_left_next;
  logic [CrcWidth-1:0] running_crc, running_crc_next;
  logic [7:0]          type_reg, type_reg_next;
  logic                halted, halted_next;

  logic [LenWidth-1:0] shifted;
  logic [LenWidth-1:0] left_dec;
  logic [CrcWidth-1:0] crc_from_run;
  logic [CrcWidth-1:0] crc_from_ones;

  // Reflected CRC-32 over one byte, one polynomial step per bit.
  function automatic logic [CrcWidth-1:0] crc_byte(input logic [CrcWidth-1:0] crc_in,
                                                   input logic [7:0] b);
    logic [CrcWidth-1:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  assign shifted       = {byte_in, length_shift[LenWidth-1:8]};
  assign left_dec      = bytes_left - 32'd1;
  assign crc_from_run  = crc_byte(running_crc, byte_in);
  assign crc_from_ones = crc_byte(CRC_ONES, byte_in);

  always_comb begin
    phase_next            = phase;
    field_byte_count_next = field_byte_count;
    length_shift_next     = length_shift;
    key_len_reg_next      = key_len_reg;
    value_len_reg_next    = value_len_reg;
    bytes_left_next       = bytes_left;
    running_crc_next      = running_crc;
    type_reg_next         = type_reg;
    halted_next           = halted;
    res_valid             = 1'b0;
    res.kind              = KIND_LOG;
    res.data              = 8'd0;
    res.rtype             = type_reg;
    res.ksz               = key_len_reg;
    res.vsz               = value_len_reg;
    res.status            = ST_OK;

    if (step && !halted) begin
      if (done_in) begin
        res_valid   = 1'b1;
        res.kind    = KIND_LOG;
        res.ksz     = '0;
        res.vsz     = '0;
        halted_next = 1'b1;
        unique case (phase)
          PH_KLEN: res.status = ST_TRUNC_KLEN;
          PH_VLEN: res.status = ST_TRUNC_VLEN;
          PH_KEY:  res.status = ST_TRUNC_KEY;
          PH_VAL:  res.status = ST_TRUNC_VAL;
          PH_CSUM: res.status = ST_TRUNC_CSUM;
          default: begin
            res.status = ST_OK;
            res.rtype  = 8'd0;
          end
        endcase
      end else begin
        unique case (phase)
          PH_KLEN, PH_VLEN, PH_CSUM: begin
            field_byte_count_next = field_byte_count + 2'd1;
            if (field_byte_count != 2'd3) begin
              length_shift_next = shifted;
            end else begin
              length_shift_next = '0;
              if (phase == PH_KLEN) begin
                key_len_reg_next = shifted;
                phase_next       = PH_VLEN;
              end else if (phase == PH_VLEN) begin
                value_len_reg_next = shifted;
                // Empty fields are skipped altogether.
                if (key_len_reg != '0) begin
                  phase_next      = PH_KEY;
                  bytes_left_next = key_len_reg;
                end else if (shifted != '0) begin
                  phase_next      = PH_VAL;
                  bytes_left_next = shifted;
                end else begin
                  phase_next      = PH_CSUM;
                  bytes_left_next = '0;
                end
              end else begin
                res_valid = 1'b1;
                res.kind  = KIND_REC;
                if ((running_crc ^ CRC_ONES) == shifted) begin
                  res.status       = ST_OK;
                  phase_next       = PH_TYPE;
                  running_crc_next = CRC_ONES;
                end else begin
                  res.status  = ST_MISMATCH;
                  halted_next = 1'b1;
                end
              end
            end
          end
          PH_KEY, PH_VAL: begin
            res_valid        = 1'b1;
            res.kind         = (phase == PH_KEY) ? KIND_KEY : KIND_VAL;
            res.data         = byte_in;
            running_crc_next = crc_from_run;
            bytes_left_next  = left_dec;
            if (left_dec == '0) begin
              if (phase == PH_KEY && value_len_reg != '0) begin
                phase_next      = PH_VAL;
                bytes_left_next = value_len_reg;
              end else begin
                phase_next            = PH_CSUM;
                field_byte_count_next = 2'd0;
                length_shift_next     = '0;
              end
            end
          end
          default: begin
            if (byte_in == end_marker) begin
              res_valid   = 1'b1;
              res.kind    = KIND_LOG;
              res.rtype   = byte_in;
              res.ksz     = '0;
              res.vsz     = '0;
              halted_next = 1'b1;
            end else begin
              type_reg_next         = byte_in;
              running_crc_next      = crc_from_ones;
              key_len_reg_next      = '0;
              value_len_reg_next    = '0;
              field_byte_count_next = 2'd0;
              length_shift_next     = '0;
              phase_next            = PH_KLEN;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_TYPE;
      field_byte_count <= 2'd0;
      length_shift     <= '0;
      key_len_reg      <= '0;
      value_len_reg    <= '0;
      bytes_left       <= '0;
      running_crc      <= CRC_ONES;
      type_reg         <= 8'd0;
      halted           <= 1'b0;
    end else begin
      phase            <= phase_next;
      field_byte_count <= field_byte_count_next;
      length_shift     <= length_shift_next;
      key_len_reg      <= key_len_reg_next;
      value_len_reg    <= value_len_reg_next;
      bytes_left       <= bytes_left_next;
      running_crc      <= running_crc_next;
      type_reg         <= type_reg_next;
      halted           <= halted_next;
    end
  end

endmodule

FILE: test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lrd_pkg::*;

  localparam logic [2:0] MARKER_ADDR = {REG_END_MARKER, 2'b00};
  localparam logic [2:0] SPARE_ADDR = 3'd4;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 6;

  typedef enum int {
    END_CLEAN,
    END_MARKER,
    END_TRUNC_KLEN,
    END_TRUNC_VLEN,
    END_TRUNC_KEY,
    END_TRUNC_VAL,
    END_TRUNC_CSUM,
    END_MISMATCH
  } log_end_e;

  logic        clk;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  byte_value = '0;
  logic        stream_done = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  result_kind;
  logic [7:0]  data_byte;
  logic [7:0]  record_type;
  logic [31:0] key_size;
  logic [31:0] value_size;
  logic [2:0]  status;

  log_record_deframer_crc32_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .byte_value  (byte_value),
    .stream_done (stream_done),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_kind (result_kind),
    .data_byte   (data_byte),
    .record_type (record_type),
    .key_size    (key_size),
    .value_size  (value_size),
    .status      (status)
  );

  // Deframer state as the testbench sees it, starting from the reset values.
  logic [7:0]  end_marker = '0;
  logic [2:0]  parse_phase = PH_TYPE;
  logic [1:0]  byte_idx = '0;
  logic [31:0] shift_word = '0;
  logic [31:0] key_len = '0;
  logic [31:0] val_len = '0;
  logic [31:0] remaining = '0;
  logic [31:0] crc_acc = CRC_ONES;
  logic [31:0] stored_csum = '0;
  logic [7:0]  cur_type = '0;
  logic        stopped = 1'b0;

  lrd_result_t due_results[$];
  lrd_result_t head_result;
  logic [7:0]  frame_bytes[$];

  int unsigned send_idle_pct = 34;
  int unsigned recv_idle_pct = 72;
  int unsigned beats_sent = 0;
  int unsigned err_count = 0;
  int unsigned stall_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  // Advances the parser by one accepted beat and queues the result it yields.
  function automatic void deframe_step(input logic [7:0] b, input logic done);
    lrd_result_t r;
    logic        last;
    r = '0;
    if (stopped) return;
    if (done) begin
      r.kind = KIND_LOG;
      r.rtype = cur_type;
      case (parse_phase)
        PH_KLEN: r.status = ST_TRUNC_KLEN;
        PH_VLEN: r.status = ST_TRUNC_VLEN;
        PH_KEY:  r.status = ST_TRUNC_KEY;
        PH_VAL:  r.status = ST_TRUNC_VAL;
        PH_CSUM: r.status = ST_TRUNC_CSUM;
        default: begin
          r.status = ST_OK;
          r.rtype = '0;
        end
      endcase
      due_results.push_back(r);
      stopped = 1'b1;
      return;
    end
    case (parse_phase)
      PH_KLEN, PH_VLEN, PH_CSUM: begin
        shift_word = {b, shift_word[31:8]};
        last = (byte_idx == 2'd3);
        byte_idx = byte_idx + 2'd1;
        if (!last) return;
        if (parse_phase == PH_KLEN) begin
          key_len = shift_word;
          shift_word = '0;
          parse_phase = PH_VLEN;
        end else if (parse_phase == PH_VLEN) begin
          val_len = shift_word;
          if (key_len != 0) begin
            parse_phase = PH_KEY;
            remaining = key_len;
          end else if (val_len != 0) begin
            parse_phase = PH_VAL;
            remaining = val_len;
          end else begin
            parse_phase = PH_CSUM;
            remaining = '0;
          end
          byte_idx = '0;
          shift_word = '0;
        end else begin
          stored_csum = shift_word;
          shift_word = '0;
          r.kind = KIND_REC;
          r.rtype = cur_type;
          r.ksz = key_len;
          r.vsz = val_len;
          if ((crc_acc ^ CRC_ONES) == stored_csum) begin
            r.status = ST_OK;
            parse_phase = PH_TYPE;
            crc_acc = CRC_ONES;
          end else begin
            r.status = ST_MISMATCH;
            stopped = 1'b1;
          end
          due_results.push_back(r);
        end
      end
      PH_KEY, PH_VAL: begin
        r.kind = (parse_phase == PH_KEY) ? KIND_KEY : KIND_VAL;
        r.data = b;
        r.rtype = cur_type;
        r.ksz = key_len;
        r.vsz = val_len;
        r.status = ST_OK;
        due_results.push_back(r);
        crc_acc = crc_update(crc_acc, b);
        remaining = remaining - 1;
        if (remaining == 0) begin
          if (parse_phase == PH_KEY && val_len != 0) begin
            parse_phase = PH_VAL;
            remaining = val_len;
          end else begin
            parse_phase = PH_CSUM;
            byte_idx = '0;
            shift_word = '0;
          end
        end
      end
      default: begin
        if (b == end_marker) begin
          r.kind = KIND_LOG;
          r.rtype = b;
          r.status = ST_OK;
          due_results.push_back(r);
          stopped = 1'b1;
        end else begin
          cur_type = b;
          crc_acc = crc_update(CRC_ONES, b);
          key_len = '0;
          val_len = '0;
          byte_idx = '0;
          shift_word = '0;
          parse_phase = PH_KLEN;
        end
      end
    endcase
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_error($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        report_error($sformatf("result beat of kind %0d with nothing expected", result_kind));
      end else begin
        head_result = due_results.pop_front();
        check_field("result_kind", 32'(result_kind), 32'(head_result.kind));
        check_field("data_byte", 32'(data_byte), 32'(head_result.data));
        check_field("record_type", 32'(record_type), 32'(head_result.rtype));
        check_field("key_size", key_size, head_result.ksz);
        check_field("value_size", value_size, head_result.vsz);
        check_field("status", 32'(status), 32'(head_result.status));
      end
    end
  end

  // Any handshake or register access counts as progress.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Valid is only lowered for a gap, so back-to-back beats never see it drop.
  task automatic send_beat(input logic [7:0] b, input logic done);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    byte_value <= b;
    stream_done <= done;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    deframe_step(b, done);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr == MARKER_ADDR) end_marker = data[7:0];
  endtask

  task automatic check_marker_readback();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= MARKER_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (prdata[7:0] !== end_marker) begin
      report_error($sformatf("end marker reads 0x%0h, expected 0x%0h", prdata[7:0], end_marker));
    end
  endtask

  function automatic logic [7:0] pick_type();
    logic [7:0] t;
    do t = 8'($urandom_range(255)); while (t == end_marker);
    return t;
  endfunction

  // Mostly short fields, now and then a long one.
  function automatic logic [31:0] pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return 32'd0;
    if (r < 90) return 32'($urandom_range(1, 6));
    if (r < 98) return 32'($urandom_range(7, 24));
    return 32'($urandom_range(40, 80));
  endfunction

  // Builds one record and sends it; a cut below the record's length sends
  // only that many bytes and then ends the stream.
  task automatic send_record(input logic [7:0] rtype, input logic [31:0] klen,
                             input logic [31:0] vlen, input int fill,
                             input bit corrupt, input int cut);
    logic [31:0] crc;
    logic [7:0]  b;
    int          n;
    frame_bytes.delete();
    frame_bytes.push_back(rtype);
    crc = crc_update(CRC_ONES, rtype);
    for (int i = 0; i < 4; i++) frame_bytes.push_back(klen[8*i +: 8]);
    for (int i = 0; i < 4; i++) frame_bytes.push_back(vlen[8*i +: 8]);
    for (longint i = 0; i < longint'(klen) + longint'(vlen); i++) begin
      b = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
      frame_bytes.push_back(b);
      crc = crc_update(crc, b);
    end
    crc = crc ^ CRC_ONES;
    if (corrupt) crc = crc ^ (32'd1 << $urandom_range(31));
    for (int i = 0; i < 4; i++) frame_bytes.push_back(crc[8*i +: 8]);
    n = (cut >= 0 && cut < frame_bytes.size()) ? cut : frame_bytes.size();
    for (int i = 0; i < n; i++) send_beat(frame_bytes[i], 1'b0);
    if (n < frame_bytes.size()) send_beat(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic test_register_access();
    check_marker_readback();
    // A write to an unmapped register must leave the end marker alone.
    apb_write(SPARE_ADDR, 32'hFFFF_FFFF);
    check_marker_readback();
  endtask

  task automatic test_directed_records();
    send_record(8'hFF, 32'd1, 32'd0, 8'h00, 1'b0, -1);
    wait_idle();
    apb_write(MARKER_ADDR, 32'h1234_56FF);
    check_marker_readback();
    send_record(8'h00, 32'd0, 32'd1, 8'hFF, 1'b0, -1);
    send_record(8'h5A, 32'd0, 32'd0, -1, 1'b0, -1);
  endtask

  task automatic run_stream_mode(input int unsigned send_pct, input int unsigned recv_pct,
                                 input logic [7:0] marker, input int unsigned budget);
    int unsigned first_beat;
    wait_idle();
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    apb_write(MARKER_ADDR, {24'($urandom), marker});
    check_marker_readback();
    first_beat = beats_sent;
    while (beats_sent - first_beat < budget) begin
      send_record(pick_type(), pick_len(), pick_len(), -1, 1'b0, -1);
    end
  endtask

  task automatic test_random_stream();
    run_stream_mode(34, 72, 8'($urandom_range(1, 254)), 400);
    run_stream_mode(72, 34, 8'h00, 400);
    run_stream_mode(0, 0, 8'hFF, 400);
  endtask

  // Only one way of ending is possible per run, since the block halts until
  // reset; the seed picks which. Beats after the end must all be dropped.
  task automatic test_log_end();
    log_end_e    ending;
    logic [7:0]  rtype;
    logic [31:0] klen;
    logic [31:0] vlen;
    ending = log_end_e'($urandom_range(int'(END_MISMATCH)));
    rtype = pick_type();
    klen = 32'($urandom_range(1, 6));
    vlen = 32'($urandom_range(1, 6));
    case (ending)
      END_CLEAN:      send_beat(8'($urandom_range(255)), 1'b1);
      END_MARKER:     send_beat(end_marker, 1'b0);
      END_TRUNC_KLEN: send_record(rtype, klen, vlen, -1, 1'b0, $urandom_range(1, 4));
      END_TRUNC_VLEN: send_record(rtype, klen, vlen, -1, 1'b0, $urandom_range(5, 8));
      END_TRUNC_KEY:  send_record(rtype, klen, vlen, -1, 1'b0, $urandom_range(9, 8 + klen));
      END_TRUNC_VAL: begin
        send_record(rtype, klen, vlen, -1, 1'b0, $urandom_range(9 + klen, 8 + klen + vlen));
      end
      END_TRUNC_CSUM: begin
        send_record(rtype, klen, vlen, -1, 1'b0,
                    $urandom_range(9 + klen + vlen, 12 + klen + vlen));
      end
      default:        send_record(rtype, klen, vlen, -1, 1'b1, -1);
    endcase
    repeat (24) send_beat(8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_register_access();
    test_directed_records();
    test_random_stream();
    test_log_end();
    wait_idle();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/lrd_pkg.sv
hw/rtl/lrd_parser.sv
hw/rtl/log_record_deframer_crc32_top.sv
test/tb.sv
